// File: design/pulse_count_sequencer_top_assert.svh
// assertion macros used by the pulse count sequencer checker
`ifndef PULSE_COUNT_SEQUENCER_TOP_ASSERT_SVH
`define PULSE_COUNT_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define PCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcs same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcs next-cycle check failed");

`endif

// File: design/pcs_pkg.sv
// shared types and constants of the pulse count sequencer
package pcs_pkg;

    localparam int REQ_TYPE_W     = 2;
    localparam int PULSE_COUNT_W  = 8;
    localparam int PHASE_LENGTH_W = 16;

    typedef logic [REQ_TYPE_W-1:0] t_req_code;

    localparam t_req_code REQ_TICK  = 2'd0;
    localparam t_req_code REQ_START = 2'd1;
    localparam t_req_code REQ_CLOSE = 2'd2;

    typedef struct packed {
        logic reset_line;
        logic data_line;
        logic active;
        logic finished;
    } t_result;

endpackage

// File: design/pcs_ifs.sv
// request and result stream interfaces of the pulse count sequencer
interface pcs_req_if;
    logic                                 valid;
    logic                                 ready;
    pcs_pkg::t_req_code                   req_type;
    logic [pcs_pkg::PULSE_COUNT_W-1:0]    pulse_count;
    logic [pcs_pkg::PHASE_LENGTH_W-1:0]   phase_length;

    modport source (output valid, output req_type, output pulse_count,
                    output phase_length, input ready);
    modport sink   (input valid, input req_type, input pulse_count,
                    input phase_length, output ready);
endinterface

interface pcs_res_if;
    logic valid;
    logic ready;
    logic reset_line;
    logic data_line;
    logic active;
    logic finished;

    modport source (output valid, output reset_line, output data_line,
                    output active, output finished, input ready);
    modport sink   (input valid, input reset_line, input data_line,
                    input active, input finished, output ready);
endinterface

// File: design/pulse_count_sequencer_top.sv
// pulse count sequencer: drives a sound chip reset and data line from tick/start/close requests
// a result is valid in the cycle after its request transfer when the result queue is empty
// throughput: one request per cycle while ready is high; every request yields exactly one result
// a two-entry result queue keeps input ready high while one result waits downstream
// ready is low whenever both result slots are full, even in a cycle where the head is taken
// reset (i_rst_n low, synchronous) clears the sequence state and empties the result queue
module pulse_count_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcs_req_if.sink     i_req,
    pcs_res_if.source   o_res
);

    // sequence state, all cleared by reset and by a close request
    typedef struct packed {
        logic                                running;
        logic                                reset_phase_done;
        logic                                data_phase;
        logic                                pulse_high;
        logic [pcs_pkg::PHASE_LENGTH_W-1:0]  tick_counter;
        logic [pcs_pkg::PULSE_COUNT_W-1:0]   pulses_left;
        logic [pcs_pkg::PHASE_LENGTH_W-1:0]  phase_limit;
        logic                                reset_level;
        logic                                data_level;
    } t_state;

    t_state           r_st;
    t_state           n_st;
    logic             n_done;
    pcs_pkg::t_result w_res;

    // result queue: slot 0 is the head shown on the output
    pcs_pkg::t_result r_buf0;
    pcs_pkg::t_result r_buf1;
    pcs_pkg::t_result n_buf0;
    pcs_pkg::t_result n_buf1;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    logic w_push;
    logic w_pop;

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = o_res.valid && o_res.ready;

    // one step of the sequence for the request at the input
    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        case (i_req.req_type)
            pcs_pkg::REQ_TICK: begin
                if (r_st.running) begin
                    n_st.tick_counter = r_st.tick_counter + 1'b1;

                    // reset pulse phase
                    if (!n_st.reset_phase_done) begin
                        n_st.reset_level = 1'b1;
                        if (n_st.tick_counter > n_st.phase_limit) begin
                            n_st.reset_level      = 1'b0;
                            n_st.reset_phase_done = 1'b1;
                            n_st.tick_counter     = '0;
                        end
                    end

                    // low gap after reset, then the first data pulse starts
                    if (n_st.reset_phase_done && !n_st.data_phase
                        && (n_st.tick_counter > n_st.phase_limit)) begin
                        n_st.tick_counter = '0;
                        n_st.pulse_high   = 1'b1;
                        n_st.data_phase   = 1'b1;
                    end

                    // data pulses: high phase then low phase, repeated
                    if (n_st.data_phase) begin
                        if (n_st.pulse_high) begin
                            n_st.data_level = 1'b1;
                            if (n_st.tick_counter > n_st.phase_limit) begin
                                n_st.pulse_high   = 1'b0;
                                n_st.tick_counter = '0;
                            end
                        end else begin
                            n_st.data_level = 1'b0;
                            if (n_st.tick_counter > n_st.phase_limit) begin
                                n_st.tick_counter = '0;
                                if (n_st.pulses_left != '0) begin
                                    n_st.pulses_left = n_st.pulses_left - 1'b1;
                                    n_st.pulse_high  = 1'b1;
                                end else begin
                                    // last low phase over: sequence complete
                                    n_st   = '0;
                                    n_done = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            pcs_pkg::REQ_START: begin
                // a start while running only reloads count and length
                n_st.pulses_left = i_req.pulse_count;
                n_st.phase_limit = i_req.phase_length;
                n_st.running     = 1'b1;
            end
            pcs_pkg::REQ_CLOSE: begin
                n_st = '0;
            end
            default: begin
                // unused request code leaves the state alone
            end
        endcase
    end

    assign w_res.reset_line = n_st.reset_level;
    assign w_res.data_line  = n_st.data_level;
    assign w_res.active     = n_st.running;
    assign w_res.finished   = n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_push) begin
            r_st <= n_st;
        end
    end

    // queue update, order of results kept
    always_comb begin
        n_buf0 = r_buf0;
        n_buf1 = r_buf1;
        n_cnt  = r_cnt;
        case ({w_push, w_pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_buf0 = w_res;
                end else begin
                    n_buf1 = w_res;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_buf0 = r_buf1;
                n_cnt  = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd2) begin
                    n_buf0 = r_buf1;
                    n_buf1 = w_res;
                end else begin
                    n_buf0 = w_res;
                end
            end
            default: begin
                // no transfer on either side
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // payload slots need no reset
    always_ff @(posedge i_clk) begin
        r_buf0 <= n_buf0;
        r_buf1 <= n_buf1;
    end

    assign o_res.valid      = (r_cnt != 2'd0);
    assign o_res.reset_line = r_buf0.reset_line;
    assign o_res.data_line  = r_buf0.data_line;
    assign o_res.active     = r_buf0.active;
    assign o_res.finished   = r_buf0.finished;

endmodule

// File: design/pcs_checker.sv
// port-level checker for the pulse count sequencer and its bind
`include "pulse_count_sequencer_top_assert.svh"

module pcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_reset_line,
    input logic i_data_line,
    input logic i_active,
    input logic i_finished
);

    // a stalled result stays offered
    `PCS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

    // the reset pulse and the data pulses never overlap
    `PCS_ASSERT_NOW(a_lines_excl, i_clk, i_rst_n, i_res_valid, !(i_reset_line && i_data_line))

    // with no sequence running both lines are low
    `PCS_ASSERT_NOW(a_idle_low, i_clk, i_rst_n, i_res_valid && !i_active,
                    !i_reset_line && !i_data_line)

    // completion leaves the block idle
    `PCS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, i_res_valid && i_finished, !i_active)

endmodule

bind pulse_count_sequencer_top pcs_checker u_pcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_reset_line (o_res.reset_line),
    .i_data_line  (o_res.data_line),
    .i_active     (o_res.active),
    .i_finished   (o_res.finished)
);

// File: tb/testbench.sv
// self-checking testbench for the pulse count sequencer: directed and random request streams
`timescale 1ns / 1ps

module testbench;

    // request code the block leaves unused; it must be ignored
    localparam pcs_pkg::t_req_code REQ_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 1800;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        pcs_pkg::t_req_code                    code;
        logic [pcs_pkg::PULSE_COUNT_W-1:0]     pulses;
        logic [pcs_pkg::PHASE_LENGTH_W-1:0]    length;
    } t_request;

    // shadow copy of the sequencer state
    typedef struct {
        logic                                  running;
        logic                                  reset_done;
        logic                                  in_data;
        logic                                  pulse_hi;
        logic [pcs_pkg::PHASE_LENGTH_W-1:0]    ticks;
        logic [pcs_pkg::PULSE_COUNT_W-1:0]     pulses_left;
        logic [pcs_pkg::PHASE_LENGTH_W-1:0]    limit;
        logic                                  reset_lvl;
        logic                                  data_lvl;
    } t_chip_state;

    logic i_clk;
    logic i_rst_n;

    pcs_req_if req_if();
    pcs_res_if res_if();

    pulse_count_sequencer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_request          req_backlog[$];
    pcs_pkg::t_result  expected_lines[$];
    t_chip_state       chip;
    t_request          next_req;
    int unsigned       send_gap;
    int unsigned       stall_left;
    int unsigned       burst_left;
    int unsigned       error_count;

    always #2 i_clk = ~i_clk;

    // idle length for either side: mostly none or short, a few long,
    // and now and then a stretch with no idling at all
    function automatic int unsigned draw_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_chip();
        chip = '{default: '0};
    endfunction

    // one timer tick of a running sequence; returns 1 when the sequence completes
    function automatic logic tick_chip();
        chip.ticks = chip.ticks + 1'b1;
        // reset pulse
        if (!chip.reset_done) begin
            chip.reset_lvl = 1'b1;
            if (chip.ticks > chip.limit) begin
                chip.reset_lvl  = 1'b0;
                chip.reset_done = 1'b1;
                chip.ticks      = '0;
            end
        end
        // low gap, which hands over to the first high data phase
        if (chip.reset_done && !chip.in_data && chip.ticks > chip.limit) begin
            chip.ticks    = '0;
            chip.pulse_hi = 1'b1;
            chip.in_data  = 1'b1;
        end
        // data pulses
        if (chip.in_data) begin
            if (chip.pulse_hi) begin
                chip.data_lvl = 1'b1;
                if (chip.ticks > chip.limit) begin
                    chip.pulse_hi = 1'b0;
                    chip.ticks    = '0;
                end
            end else begin
                chip.data_lvl = 1'b0;
                if (chip.ticks > chip.limit) begin
                    chip.ticks = '0;
                    if (chip.pulses_left > 0) begin
                        chip.pulses_left = chip.pulses_left - 1'b1;
                        chip.pulse_hi    = 1'b1;
                    end else begin
                        clear_chip();
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // expected line levels after one accepted request
    function automatic pcs_pkg::t_result sequencer_step(t_request rq);
        pcs_pkg::t_result out;
        logic             done;
        done = 1'b0;
        case (rq.code)
            pcs_pkg::REQ_TICK: begin
                if (chip.running) done = tick_chip();
            end
            pcs_pkg::REQ_START: begin
                // a start while running only reloads count and length
                chip.pulses_left = rq.pulses;
                chip.limit       = rq.length;
                chip.running     = 1'b1;
            end
            pcs_pkg::REQ_CLOSE: begin
                clear_chip();
            end
            default: ;
        endcase
        out.reset_line = chip.reset_lvl;
        out.data_line  = chip.data_lvl;
        out.active     = chip.running;
        out.finished   = done;
        return out;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch at %0t: %s got %b want %b", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        pcs_pkg::t_result want;
        if (expected_lines.size() == 0) begin
            report_mismatch("unexpected result transfer, valid", 1'b1, 1'b0);
            return;
        end
        want = expected_lines.pop_front();
        if (res_if.reset_line !== want.reset_line)
            report_mismatch("reset_line", res_if.reset_line, want.reset_line);
        if (res_if.data_line !== want.data_line)
            report_mismatch("data_line", res_if.data_line, want.data_line);
        if (res_if.active !== want.active)
            report_mismatch("active", res_if.active, want.active);
        if (res_if.finished !== want.finished)
            report_mismatch("finished", res_if.finished, want.finished);
    endtask

    task automatic push_req(pcs_pkg::t_req_code code, int unsigned pulses,
                            int unsigned length);
        t_request rq;
        rq.code   = code;
        rq.pulses = pulses[pcs_pkg::PULSE_COUNT_W-1:0];
        rq.length = length[pcs_pkg::PHASE_LENGTH_W-1:0];
        req_backlog.push_back(rq);
    endtask

    task automatic push_ticks(int unsigned n);
        repeat (n) push_req(pcs_pkg::REQ_TICK, 0, 0);
    endtask

    // request driver: one transfer per handshake, payload held while ready is low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                next_req.code   = req_if.req_type;
                next_req.pulses = req_if.pulse_count;
                next_req.length = req_if.phase_length;
                expected_lines.push_back(sequencer_step(next_req));
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap == 0 && req_backlog.size() > 0) begin
                    next_req = req_backlog.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.req_type     <= next_req.code;
                    req_if.pulse_count  <= next_req.pulses;
                    req_if.phase_length <= next_req.length;
                    send_gap = draw_gap();
                end else begin
                    req_if.valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_result();
                stall_left = draw_gap();
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned n_pulses;
        int unsigned n_len;
        int unsigned n_ticks;
        int unsigned pick;

        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = pcs_pkg::REQ_TICK;
        req_if.pulse_count  = '0;
        req_if.phase_length = '0;
        res_if.ready        = 1'b0;
        send_gap            = 0;
        stall_left          = 0;
        burst_left          = 0;
        error_count         = 0;
        clear_chip();

        // directed part
        push_req(pcs_pkg::REQ_TICK, 0, 0);          // tick while idle does nothing
        push_req(REQ_UNUSED, 255, 65535);           // unused code, all payload bits high
        push_req(pcs_pkg::REQ_CLOSE, 0, 0);         // close while idle
        push_req(pcs_pkg::REQ_START, 0, 0);         // shortest full sequence
        push_ticks(5);                              // runs to finished, then idle tick
        push_req(pcs_pkg::REQ_START, 1, 1);
        push_ticks(3);
        push_req(pcs_pkg::REQ_START, 255, 65535);   // reload while running, widest values
        push_ticks(3);                              // max length: phase never ends
        push_req(pcs_pkg::REQ_CLOSE, 0, 0);         // abort mid-sequence
        push_req(pcs_pkg::REQ_TICK, 0, 0);
        push_req(REQ_UNUSED, 0, 0);

        // random part
        while (req_backlog.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // well-formed sequence with small values, mostly ticked to its end, sometimes cut short or aborted
                n_pulses = $urandom_range(0, 3);
                n_len    = $urandom_range(0, 4);
                push_req(pcs_pkg::REQ_START, n_pulses, n_len);
                n_ticks = 2 * (n_len + 1) * (n_pulses + 2) + $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) n_ticks = n_ticks - $urandom_range(0, 3);
                for (int i = 0; i < n_ticks; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3) begin
                        push_req(pcs_pkg::REQ_START, $urandom_range(0, 3),
                                 $urandom_range(0, 4));
                    end else if (pick < 5) begin
                        push_req(pcs_pkg::REQ_CLOSE, $urandom_range(0, 255),
                                 $urandom_range(0, 65535));
                        break;
                    end else begin
                        push_req(pcs_pkg::REQ_TICK, $urandom_range(0, 255),
                                 $urandom_range(0, 65535));
                    end
                end
            end else if (pick < 85) begin
                // wide values: a few ticks, then abort
                push_req(pcs_pkg::REQ_START, $urandom_range(0, 255),
                         $urandom_range(0, 65535));
                push_ticks($urandom_range(1, 8));
                push_req(pcs_pkg::REQ_CLOSE, 0, 0);
            end else begin
                // noise
                push_req(pcs_pkg::t_req_code'($urandom_range(0, 3)),
                         $urandom_range(0, 255), $urandom_range(0, 65535));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything sent and every result checked
        do @(negedge i_clk);
        while (req_backlog.size() > 0 || req_if.valid || expected_lines.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/pcs_pkg.sv
design/pcs_ifs.sv
design/pulse_count_sequencer_top.sv
design/pcs_checker.sv
tb/testbench.sv
